FILE: hdl/tsdc_pkg.sv
`timescale 1ns / 1ps

package tsdc_pkg;

  // Detector phase codes.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WANT_IN  = 2'd1,
    PH_WANT_OUT = 2'd2
  } phase_t;

  // Event codes reported with every result.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ENTER   = 2'd1,
    EV_LEAVE   = 2'd2,
    EV_ABANDON = 2'd3
  } event_t;

  // Configuration register indexes.
  localparam logic CFG_COOLDOWN = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic [15:0] COOLDOWN_RESET = 16'd1000;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
  localparam logic [7:0]  COUNT_MAX      = 8'd255;

  typedef struct packed {
    logic        command;
    logic        outside_level;
    logic        inside_level;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [7:0] person_count;
    logic [1:0] event_res;
    logic [1:0] detector_phase;
    logic       in_cooldown;
  } result_t;

  typedef struct packed {
    logic [15:0] cooldown_ms;
    logic [15:0] transition_timeout_ms;
  } cfg_t;

endpackage

FILE: hdl/tsdc_sample_if.sv
`timescale 1ns / 1ps

interface tsdc_sample_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        outside_level;
  logic        inside_level;
  logic [31:0] now_ms;

  modport source (output valid, command, outside_level, inside_level, now_ms, input ready);
  modport sink (input valid, command, outside_level, inside_level, now_ms, output ready);
endinterface

interface tsdc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] person_count;
  logic [1:0] event_res;
  logic [1:0] detector_phase;
  logic       in_cooldown;

  modport source (output valid, person_count, event_res, detector_phase, in_cooldown,
                  input ready);
  modport sink (input valid, person_count, event_res, detector_phase, in_cooldown,
                output ready);
endinterface

FILE: hdl/tsdc_detector.sv
`timescale 1ns / 1ps

module tsdc_detector (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_valid,
  input  tsdc_pkg::sample_t item,
  input  tsdc_pkg::cfg_t    cfg,
  output tsdc_pkg::result_t res
);
  import tsdc_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] first_edge_time, first_edge_time_next;
  logic [31:0] last_count_time, last_count_time_next;
  logic        prev_outside, prev_outside_next;
  logic        prev_inside, prev_inside_next;
  logic [7:0]  count, count_next;
  logic        primed, primed_next;

  logic        out_edge;
  logic        in_edge;
  logic [31:0] cool_elapsed;
  logic [31:0] trans_elapsed;
  logic        cooling;
  logic        trans_expired;
  event_t      ev;

  assign out_edge      = item.outside_level & ~prev_outside;
  assign in_edge       = item.inside_level & ~prev_inside;
  assign cool_elapsed  = item.now_ms - last_count_time;
  assign trans_elapsed = item.now_ms - first_edge_time;
  // A stored time of zero means the timer is not running.
  assign cooling       = (last_count_time != '0) &&
                         (cool_elapsed < {16'd0, cfg.cooldown_ms});
  assign trans_expired = (first_edge_time != '0) &&
                         (trans_elapsed >= {16'd0, cfg.transition_timeout_ms});

  always_comb begin
    phase_next           = phase;
    first_edge_time_next = first_edge_time;
    last_count_time_next = last_count_time;
    prev_outside_next    = prev_outside;
    prev_inside_next     = prev_inside;
    count_next           = count;
    primed_next          = primed;
    ev                   = EV_NONE;
    res.in_cooldown      = 1'b0;

    if (item.command) begin
      count_next           = '0;
      phase_next           = PH_IDLE;
      first_edge_time_next = '0;
      last_count_time_next = '0;
    end else if (!primed) begin
      prev_outside_next = item.outside_level;
      prev_inside_next  = item.inside_level;
      primed_next       = 1'b1;
    end else begin
      prev_outside_next = item.outside_level;
      prev_inside_next  = item.inside_level;
      if (cooling) begin
        res.in_cooldown = 1'b1;
      end else begin
        unique case (phase)
          PH_WANT_IN: begin
            if (in_edge) begin
              if (count != COUNT_MAX) count_next = count + 8'd1;
              ev                   = EV_ENTER;
              phase_next           = PH_IDLE;
              last_count_time_next = item.now_ms;
              first_edge_time_next = '0;
            end else if (trans_expired) begin
              phase_next           = PH_IDLE;
              first_edge_time_next = '0;
              ev                   = EV_ABANDON;
            end
          end
          PH_WANT_OUT: begin
            if (out_edge) begin
              if (count != '0) count_next = count - 8'd1;
              ev                   = EV_LEAVE;
              phase_next           = PH_IDLE;
              last_count_time_next = item.now_ms;
              first_edge_time_next = '0;
            end else if (trans_expired) begin
              phase_next           = PH_IDLE;
              first_edge_time_next = '0;
              ev                   = EV_ABANDON;
            end
          end
          default: begin
            // The outside edge wins when both rise together.
            phase_next = PH_IDLE;
            if (out_edge) begin
              phase_next           = PH_WANT_IN;
              first_edge_time_next = item.now_ms;
            end else if (in_edge) begin
              phase_next           = PH_WANT_OUT;
              first_edge_time_next = item.now_ms;
            end
          end
        endcase
      end
    end

    res.person_count   = count_next;
    res.event_res      = ev;
    res.detector_phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      first_edge_time <= '0;
      last_count_time <= '0;
      prev_outside    <= 1'b0;
      prev_inside     <= 1'b0;
      count           <= '0;
      primed          <= 1'b0;
    end else if (step_valid) begin
      phase           <= phase_next;
      first_edge_time <= first_edge_time_next;
      last_count_time <= last_count_time_next;
      prev_outside    <= prev_outside_next;
      prev_inside     <= prev_inside_next;
      count           <= count_next;
      primed          <= primed_next;
    end
  end

  a_cmd_clears: assert property (@(posedge clk) disable iff (rst)
    step_valid && item.command |=> count == '0 && phase == PH_IDLE &&
      last_count_time == '0 && first_edge_time == '0)
    else $error("reset command did not clear the detector");

  a_enter_nonzero: assert property (@(posedge clk) disable iff (rst)
    step_valid && res.event_res == EV_ENTER |-> res.person_count != '0)
    else $error("entry left the count at zero");

  a_cool_quiet: assert property (@(posedge clk) disable iff (rst)
    step_valid && res.in_cooldown |-> res.event_res == EV_NONE && phase_next == phase)
    else $error("detector moved during cooldown");

  a_idle_no_timer: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> first_edge_time == '0)
    else $error("transition timer running while idle");

endmodule

FILE: hdl/two_sensor_direction_counter.sv
`timescale 1ns / 1ps

// Two-sensor direction counter.
// The sample channel carries one transfer per sensor sample or reset-count
// command: the outside and inside motion levels and a millisecond timestamp.
// The result channel returns exactly one transfer per sample: the person
// count, the event seen (entered, left, abandoned transition), the detector
// phase and whether the sample fell within the cooldown window.
// Configuration is a plain write port; index 0 is the cooldown in ms,
// index 1 the transition timeout in ms. Write it only while no sample is
// in flight.
// A sample is captured in the input register, and its result is computed
// combinationally and loaded into the output register once that register
// is free. Throughput is one sample per cycle while the receiver keeps
// ready high, as the state update between the registers is combinational.
// Reset clears the detector, the count and both registers' valid flags and
// restores the default timings; the first sample after reset only records
// the sensor levels. When the receiver stalls, the output register holds
// its result; the input register takes one more sample only if it is
// empty, and then the sample channel deasserts ready.
module two_sensor_direction_counter (
  input  logic        clk,
  input  logic        rst,
  tsdc_sample_if.sink   sample,
  tsdc_result_if.source result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import tsdc_pkg::*;

  cfg_t    cfg;
  sample_t in_reg;
  logic    in_valid;
  result_t res_next;
  result_t out_reg;
  logic    out_valid;
  logic    out_free;
  logic    advance;

  // The output register can take a result when empty or being drained.
  assign out_free     = !out_valid || result.ready;
  assign advance      = in_valid && out_free;
  assign sample.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cooldown_ms           <= COOLDOWN_RESET;
      cfg.transition_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COOLDOWN: cfg.cooldown_ms           <= cfg_data;
        CFG_TIMEOUT:  cfg.transition_timeout_ms <= cfg_data;
        default:      cfg.cooldown_ms           <= cfg.cooldown_ms;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_reg.command       <= sample.command;
      in_reg.outside_level <= sample.outside_level;
      in_reg.inside_level  <= sample.inside_level;
      in_reg.now_ms        <= sample.now_ms;
    end
  end

  // The detector commits its state only when the result moves on.
  tsdc_detector u_detector (
    .clk        (clk),
    .rst        (rst),
    .step_valid (advance),
    .item       (in_reg),
    .cfg        (cfg),
    .res        (res_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.person_count   = out_reg.person_count;
  assign result.event_res      = out_reg.event_res;
  assign result.detector_phase = out_reg.detector_phase;
  assign result.in_cooldown    = out_reg.in_cooldown;

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_reg))
    else $error("pending sample lost while output stalled");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_reg))
    else $error("stalled result overwritten");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("computed result not presented");

endmodule

FILE: tb/sv/two_sensor_direction_counter_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the two-sensor direction counter.
//
// Samples go in on the sample channel and every transfer there causes exactly
// one transfer on the result channel. A predictor below keeps its own copy of
// the detector state. As each sample transfer is taken, it works out the
// result that the block must return and queues it. The checker compares every
// result transfer, field by field, with the oldest queued result.
module two_sensor_direction_counter_test;
  import tsdc_pkg::*;

  // Sample command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // The run is abandoned after this many cycles with no transfer on either
  // channel. The longest quiet spell in a correct run is the receiver
  // hold-off plus the draining of the pipeline, so this leaves a wide margin.
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  tsdc_sample_if sample_ch ();
  tsdc_result_if result_ch ();

  two_sensor_direction_counter DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted detector state, mirrored from what the block should hold.
  phase_t      det_phase;
  logic [31:0] first_edge_ms;
  logic [31:0] last_count_ms;
  logic        prev_out;
  logic        prev_in;
  logic [7:0]  head_count;
  logic        primed;
  logic [15:0] cooldown_cfg;
  logic [15:0] timeout_cfg;

  // Results that the block still owes us, oldest first.
  result_t expected_results[$];

  logic [31:0] stamp_ms;
  bit          idle_enabled;
  int          hold_cycles;
  int          mismatches;
  int          quiet_cycles;

  always #5 clk = ~clk;

  // A timer is live only when its start stamp is nonzero. Elapsed time is a
  // plain 32-bit difference, so it survives a wrap of the millisecond clock.
  function automatic bit timer_done(logic [31:0] start, logic [31:0] now,
                                    logic [15:0] limit);
    if (start == 32'd0)
      return 1'b0;
    return (now - start) >= {16'd0, limit};
  endfunction

  // Advances the predicted state by one sample and returns its result.
  function automatic result_t predict_step(sample_t s);
    result_t r;
    logic    out_rise;
    logic    in_rise;
    event_t  ev;
    logic    cool;
    ev   = EV_NONE;
    cool = 1'b0;
    if (s.command == CMD_CLEAR) begin
      // The levels and the primed flag survive a clear.
      head_count    = 8'd0;
      det_phase     = PH_IDLE;
      first_edge_ms = 32'd0;
      last_count_ms = 32'd0;
    end else if (!primed) begin
      prev_out = s.outside_level;
      prev_in  = s.inside_level;
      primed   = 1'b1;
    end else begin
      out_rise = s.outside_level && !prev_out;
      in_rise  = s.inside_level && !prev_in;
      if (last_count_ms != 32'd0 && !timer_done(last_count_ms, s.now_ms, cooldown_cfg)) begin
        cool = 1'b1;
      end else begin
        case (det_phase)
          PH_WANT_IN: begin
            if (in_rise) begin
              if (head_count != COUNT_MAX)
                head_count = head_count + 8'd1;
              ev            = EV_ENTER;
              det_phase     = PH_IDLE;
              last_count_ms = s.now_ms;
              first_edge_ms = 32'd0;
            end else if (timer_done(first_edge_ms, s.now_ms, timeout_cfg)) begin
              ev            = EV_ABANDON;
              det_phase     = PH_IDLE;
              first_edge_ms = 32'd0;
            end
          end
          PH_WANT_OUT: begin
            if (out_rise) begin
              if (head_count != 8'd0)
                head_count = head_count - 8'd1;
              ev            = EV_LEAVE;
              det_phase     = PH_IDLE;
              last_count_ms = s.now_ms;
              first_edge_ms = 32'd0;
            end else if (timer_done(first_edge_ms, s.now_ms, timeout_cfg)) begin
              ev            = EV_ABANDON;
              det_phase     = PH_IDLE;
              first_edge_ms = 32'd0;
            end
          end
          default: begin
            // With both edges at once the outside edge takes precedence.
            det_phase = PH_IDLE;
            if (out_rise) begin
              det_phase     = PH_WANT_IN;
              first_edge_ms = s.now_ms;
            end else if (in_rise) begin
              det_phase     = PH_WANT_OUT;
              first_edge_ms = s.now_ms;
            end
          end
        endcase
      end
      prev_out = s.outside_level;
      prev_in  = s.inside_level;
    end
    r.person_count   = head_count;
    r.event_res      = ev;
    r.detector_phase = det_phase;
    r.in_cooldown    = cool;
    return r;
  endfunction

  // Moves the millisecond clock forward by a gap that lands, with roughly
  // equal odds, inside a window, at the cooldown or timeout edge or well past it.
  function automatic logic [31:0] next_stamp();
    logic [31:0] reach;
    reach = {16'd0, cooldown_cfg} + {16'd0, timeout_cfg} + 32'd2;
    case ($urandom_range(4))
      0: stamp_ms = stamp_ms + $urandom_range(0, 20);
      1: stamp_ms = stamp_ms + $urandom_range(0, reach);
      2: stamp_ms = stamp_ms + {16'd0, timeout_cfg} + $urandom_range(0, 2) - 32'd1;
      3: stamp_ms = stamp_ms + {16'd0, cooldown_cfg} + $urandom_range(0, 2) - 32'd1;
      default: stamp_ms = stamp_ms + reach + $urandom_range(0, reach);
    endcase
    return stamp_ms;
  endfunction

  // Offers one sample, waits for its transfer and queues the predicted
  // result. It returns at the rising edge of the transfer with valid still
  // high; with idle_enabled clear, back-to-back calls keep it busy every cycle.
  task automatic send_sample(input logic cmd, input logic out_lvl, input logic in_lvl,
                             input logic [31:0] stamp);
    sample_t item;
    item.command       = cmd;
    item.outside_level = out_lvl;
    item.inside_level  = in_lvl;
    item.now_ms        = stamp;
    @(negedge clk);
    if (idle_enabled && $urandom_range(99) < 20) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.command       <= item.command;
    sample_ch.outside_level <= item.outside_level;
    sample_ch.inside_level  <= item.inside_level;
    sample_ch.now_ms        <= item.now_ms;
    do @(posedge clk); while (!sample_ch.ready);
    expected_results.push_back(predict_step(item));
  endtask

  // Stops offering samples and waits until every owed result has arrived,
  // then lets the two-stage pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Timing registers only change while the block is idle.
  task automatic set_timing(input logic [15:0] cooldown, input logic [15:0] timeout);
    wait_drained();
    write_reg(CFG_COOLDOWN, cooldown);
    write_reg(CFG_TIMEOUT, timeout);
    cooldown_cfg = cooldown;
    timeout_cfg  = timeout;
  endtask

  // A clear before anything else keeps the block unprimed; the first real
  // sample then only records the levels.
  task automatic test_priming();
    send_sample(CMD_CLEAR, 1'b1, 1'b1, 32'd5);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd10);
  endtask

  // An entry that starts with both edges at once (outside wins), then the
  // cooldown right up to its last millisecond and just past it.
  task automatic test_entry_and_cooldown();
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd20);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd30);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd50);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd60);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd500);
    send_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd1059);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd1060);
  endtask

  // One exit brings the count back to zero; a second exit at zero must not
  // wrap the count but is still reported.
  task automatic test_exit_at_zero();
    send_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd1100);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd1200);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd2200);
    send_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd2300);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd2400);
  endtask

  // A pending transition one millisecond short of the timeout, then at it;
  // after that an inside edge that comes long after the timeout still counts.
  task automatic test_transition_timeout();
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd3400);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd3500);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd5499);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd5500);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd5600);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd9000);
  endtask

  // A first edge stamped zero never times out, and a count stamped zero
  // starts no cooldown.
  task automatic test_zero_stamp();
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FF00);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd0);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'h7000_0000);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd0);
  endtask

  // With both windows at zero, a pending transition dies on the very next
  // sample without its edge and nothing is ever in cooldown.
  task automatic test_zero_windows();
    set_timing(16'd0, 16'd0);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd100);
    send_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd100);
    send_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd100);
    send_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd101);
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd102);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd102);
  endtask

  // Enough back-to-back entries to run the count into its ceiling, one exit
  // down from there, and a clear at the end.
  task automatic test_saturation();
    set_timing(16'd0, 16'hFFFF);
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, stamp_ms);
    for (int n = 0; n < 258; n++) begin
      stamp_ms = stamp_ms + $urandom_range(1, 5);
      send_sample(CMD_SAMPLE, 1'b1, 1'b0, stamp_ms);
      stamp_ms = stamp_ms + $urandom_range(1, 5);
      send_sample(CMD_SAMPLE, 1'b0, 1'b1, stamp_ms);
    end
    send_sample(CMD_SAMPLE, 1'b0, 1'b0, next_stamp());
    send_sample(CMD_SAMPLE, 1'b0, 1'b1, next_stamp());
    send_sample(CMD_SAMPLE, 1'b1, 1'b1, next_stamp());
    send_sample(CMD_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
  endtask

  // One random burst of activity. Most are complete passages in either
  // direction, some are half passages left to time out, the rest is noise
  // on the sensors, jumps of the clock and the odd clear.
  task automatic random_passage();
    int   kind;
    logic out_lvl;
    logic in_lvl;
    kind = $urandom_range(99);
    if (kind < 3) begin
      send_sample(CMD_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
    end else if (kind < 33) begin
      send_sample(CMD_SAMPLE, 1'b0, 1'b0, next_stamp());
      send_sample(CMD_SAMPLE, 1'b1, 1'b0, next_stamp());
      send_sample(CMD_SAMPLE, 1'($urandom_range(1)), 1'b1, next_stamp());
    end else if (kind < 63) begin
      send_sample(CMD_SAMPLE, 1'b0, 1'b0, next_stamp());
      send_sample(CMD_SAMPLE, 1'b0, 1'b1, next_stamp());
      send_sample(CMD_SAMPLE, 1'b1, 1'($urandom_range(1)), next_stamp());
    end else if (kind < 78) begin
      out_lvl = 1'($urandom_range(1));
      in_lvl  = !out_lvl;
      send_sample(CMD_SAMPLE, 1'b0, 1'b0, next_stamp());
      repeat ($urandom_range(2, 4))
        send_sample(CMD_SAMPLE, out_lvl, in_lvl, next_stamp());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(3) == 0)
          stamp_ms = $urandom();
        send_sample(CMD_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    next_stamp());
      end
    end
  endtask

  // Several timing settings, the extremes among them. One setting runs under
  // a long receiver hold-off so that both pipeline stages fill and the input
  // stalls; another runs with no idle cycles on either side.
  task automatic test_random_traffic();
    logic [15:0] cool_set[5];
    logic [15:0] tmo_set[5];
    cool_set = '{16'd1000, 16'd25, 16'hFFFF, 16'd0, 16'd0};
    tmo_set  = '{16'd2000, 16'd120, 16'hFFFF, 16'd0, 16'd0};
    cool_set[4] = 16'($urandom_range(1, 3000));
    tmo_set[4]  = 16'($urandom_range(1, 3000));
    for (int p = 0; p < 5; p++) begin
      set_timing(cool_set[p], tmo_set[p]);
      idle_enabled = (p != 2);
      if (p == 1)
        hold_cycles = HOLD_OFF_LEN;
      stamp_ms = $urandom();
      repeat (40) random_passage();
    end
    idle_enabled = 1'b1;
  endtask

  // Receiver side: a pending hold-off wins, otherwise ready drops at random.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      result_ch.ready <= !(idle_enabled && $urandom_range(99) < 17);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result count=%0d event=%0d phase=%0d cooldown=%0d",
                   $realtime, result_ch.person_count, result_ch.event_res,
                   result_ch.detector_phase, result_ch.in_cooldown);
      end else begin
        want = expected_results.pop_front();
        if (result_ch.person_count !== want.person_count ||
            result_ch.event_res !== want.event_res ||
            result_ch.detector_phase !== want.detector_phase ||
            result_ch.in_cooldown !== want.in_cooldown) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result mismatch, expected count=%0d event=%0d phase=%0d",
                     $realtime, want.person_count, want.event_res, want.detector_phase,
                     " cooldown=%0d, got count=%0d event=%0d phase=%0d cooldown=%0d",
                     want.in_cooldown, result_ch.person_count, result_ch.event_res,
                     result_ch.detector_phase, result_ch.in_cooldown);
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_COOLDOWN;
    cfg_data                = 16'd0;
    sample_ch.valid         = 1'b0;
    sample_ch.command       = CMD_SAMPLE;
    sample_ch.outside_level = 1'b0;
    sample_ch.inside_level  = 1'b0;
    sample_ch.now_ms        = 32'd0;
    result_ch.ready         = 1'b0;
    idle_enabled            = 1'b1;
    hold_cycles             = 0;
    mismatches              = 0;
    quiet_cycles            = 0;
    stamp_ms                = 32'd20000;

    det_phase     = PH_IDLE;
    first_edge_ms = 32'd0;
    last_count_ms = 32'd0;
    prev_out      = 1'b0;
    prev_in       = 1'b0;
    head_count    = 8'd0;
    primed        = 1'b0;
    cooldown_cfg  = COOLDOWN_RESET;
    timeout_cfg   = TIMEOUT_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_priming();
    test_entry_and_cooldown();
    test_exit_at_zero();
    test_transition_timeout();
    test_zero_stamp();
    test_zero_windows();
    test_saturation();
    test_random_traffic();

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
